FILE: hdl/rdt_pkg.sv
// Shared types and constants for the region descriptor table.
// Used by rdt_blk, region_descriptor_table, rdt_chk and tb; depends on nothing else.
`default_nettype none

package rdt_pkg;

	// Table geometry and address space
	localparam int ENTRIES   = 64;
	localparam int PAGE_LOG2 = 12;
	localparam int ADDR_BITS = 32;
	localparam int MAX_RES   = 64;

	localparam int ID_W   = $clog2(ENTRIES);
	localparam int LOG_W  = $clog2(ADDR_BITS + 1);
	localparam int RES_W  = $clog2(MAX_RES);
	localparam int PAGE   = 1 << PAGE_LOG2;

	// Field widths fixed by the interface
	localparam int CMD_W    = 3;
	localparam int DSIN_W   = 8;
	localparam int DSOUT_W  = 6;
	localparam int WORD_W   = 32;
	localparam int TASK_W   = 11;
	localparam int PLOG_W   = 6;

	// Page masks in the address width and in the carry-extended width
	localparam logic [ADDR_BITS-1:0] PAGE_MASK  = ~ADDR_BITS'(PAGE - 1);
	localparam logic [ADDR_BITS:0]   PAGE_M1_X  = (ADDR_BITS + 1)'(PAGE - 1);
	localparam logic [ADDR_BITS:0]   ROUND_MASK = ~PAGE_M1_X;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 3'd0,
		CMD_MAP   = 3'd1,
		CMD_FAULT = 3'd2,
		CMD_CLOSE = 3'd3,
		CMD_PHYS  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_INVALID = 3'd1,
		STS_NOFREE  = 3'd2,
		STS_WDENIED = 3'd3,
		STS_BEYOND  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EXEC,
		ST_SCAN,
		ST_CLOSE
	} state_t;

	// One result transaction
	typedef struct packed {
		status_t             status;
		logic [DSOUT_W-1:0]  ds_id_out;
		logic [WORD_W-1:0]   page_addr;
		logic [PLOG_W-1:0]   page_log2;
		logic [WORD_W-1:0]   avail_len;
		logic [WORD_W-1:0]   send_base;
		logic                unmap_valid;
		logic [TASK_W-1:0]   unmap_task;
		logic                last;
	} res_t;

	// One step of the close block walk
	typedef struct packed {
		logic [LOG_W-1:0]     fp;
		logic [ADDR_BITS-1:0] next_addr;
		logic [ADDR_BITS:0]   next_size;
	} blk_step_t;

endpackage

`default_nettype wire

FILE: hdl/rdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module rdt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/rdt_blk.sv
// Close walk step: largest naturally aligned power-of-two block at addr
// that fits in size. Depends on rdt_pkg.
`default_nettype none

module rdt_blk (
	input  wire logic [rdt_pkg::ADDR_BITS-1:0] addr,
	input  wire logic [rdt_pkg::ADDR_BITS:0]   size,
	output rdt_pkg::blk_step_t                 step
);

	logic [rdt_pkg::LOG_W-1:0]     tz;
	logic [rdt_pkg::LOG_W-1:0]     tb;
	logic [rdt_pkg::LOG_W-1:0]     fp;
	logic [rdt_pkg::ADDR_BITS:0]   blk;

	// alignment of the address; zero counts as fully aligned
	always_comb begin
		tz = rdt_pkg::LOG_W'(rdt_pkg::ADDR_BITS);
		for (int i = rdt_pkg::ADDR_BITS - 1; i >= 0; i--) begin
			if (addr[i]) begin
				tz = rdt_pkg::LOG_W'(i);
			end
		end
	end

	// highest set bit of the remaining size
	always_comb begin
		tb = '0;
		for (int i = 0; i <= rdt_pkg::ADDR_BITS; i++) begin
			if (size[i]) begin
				tb = rdt_pkg::LOG_W'(i);
			end
		end
	end

	assign fp  = (tz < tb) ? tz : tb;
	assign blk = (rdt_pkg::ADDR_BITS + 1)'(1) << fp;

	assign step.fp        = fp;
	assign step.next_size = size - blk;
	assign step.next_addr = addr + blk[rdt_pkg::ADDR_BITS-1:0];

endmodule

`default_nettype wire

FILE: hdl/region_descriptor_table.sv
// Region descriptor table: a table of read-only memory regions with alloc,
// map, fault, close and physical address commands.
//
// Usage: present a command on the input ports with start high; it is taken
// at a rising edge where busy is low. busy stays high until the command's
// last result has been issued. Each result shows for one cycle with
// result_valid high; last marks the final result of the command. The
// receiver cannot stall, and busy is low while the final result shows, so
// the next command may be taken in that cycle.
//
// Sequence: map, fault, phys and rejected commands give one result, from
// the DECODE and EXEC states through the result register. Alloc walks the
// valid bits one entry per cycle from entry 0 until it finds the lowest
// free entry, or to the last entry when the table is full. Close reads the
// entry, then issues one block per cycle from the shared block-step unit,
// at most 64 blocks. Descriptors live in a registered-read RAM, so each
// entry is fetched in DECODE before it is evaluated in EXEC.
//
// Reset clears all valid bits at once; no clearing pass is needed and the
// block is ready right after reset.
// Depends on rdt_pkg, rdt_ram and rdt_blk.
`default_nettype none

module region_descriptor_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [rdt_pkg::CMD_W-1:0]   cmd,
	input  wire logic [rdt_pkg::DSIN_W-1:0]  ds_id,
	input  wire logic [rdt_pkg::WORD_W-1:0]  base_addr,
	input  wire logic [rdt_pkg::WORD_W-1:0]  length,
	input  wire logic [rdt_pkg::WORD_W-1:0]  offset,
	input  wire logic                        write_flag,
	input  wire logic                        partial_flag,
	input  wire logic                        whole_flag,
	input  wire logic [rdt_pkg::WORD_W-1:0]  recv_offset,
	input  wire logic [rdt_pkg::TASK_W-1:0]  client_task,
	output logic                             result_valid,
	output logic [2:0]                       status,
	output logic [rdt_pkg::DSOUT_W-1:0]      ds_id_out,
	output logic [rdt_pkg::WORD_W-1:0]       page_addr,
	output logic [rdt_pkg::PLOG_W-1:0]       page_log2,
	output logic [rdt_pkg::WORD_W-1:0]       avail_len,
	output logic [rdt_pkg::WORD_W-1:0]       send_base,
	output logic                             unmap_valid,
	output logic [rdt_pkg::TASK_W-1:0]       unmap_task,
	output logic                             last
);

	localparam int AB = rdt_pkg::ADDR_BITS;

	rdt_pkg::state_t state_q, state_d;

	// latched command
	logic [rdt_pkg::CMD_W-1:0]  cmd_q;
	logic [rdt_pkg::DSIN_W-1:0] ds_id_q;
	logic [rdt_pkg::WORD_W-1:0] base_q, length_q, offset_q, recv_q;
	logic                       write_q, partial_q, whole_q;
	logic [rdt_pkg::TASK_W-1:0] task_q;

	logic [rdt_pkg::ENTRIES-1:0] entry_valid_q;
	logic [rdt_pkg::ID_W-1:0]    scan_q;
	logic [AB-1:0]               cl_addr_q;
	logic [AB:0]                 cl_size_q;
	logic [rdt_pkg::RES_W-1:0]   cl_cnt_q;

	rdt_pkg::res_t res_q, res_d;
	logic          res_valid_q, emit;

	// descriptor RAM: {base, size}
	logic          ram_we;
	logic [2*AB-1:0] ram_rdata;
	logic [AB-1:0]   rd_base, rd_size;

	logic accept;
	logic id_ok, beyond, scan_free, scan_end, close_go, cl_last;
	logic set_valid, clr_valid, cl_load;
	logic [rdt_pkg::ID_W-1:0] idx;
	logic [AB-1:0] sum, rem;
	logic [AB:0]   rsize;
	rdt_pkg::blk_step_t step;

	assign accept = start && !busy;
	assign busy   = (state_q != rdt_pkg::ST_IDLE);
	assign idx    = ds_id_q[rdt_pkg::ID_W-1:0];

	rdt_ram #(
		.WIDTH(2 * AB),
		.DEPTH(rdt_pkg::ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(scan_q),
		.wdata({base_q[AB-1:0], length_q[AB-1:0]}),
		.raddr(idx),
		.rdata(ram_rdata)
	);

	assign rd_base = ram_rdata[2*AB-1:AB];
	assign rd_size = ram_rdata[AB-1:0];

	// entry checks and address arithmetic on the fetched descriptor
	assign id_ok  = ({1'b0, ds_id_q} < (rdt_pkg::DSIN_W + 1)'(rdt_pkg::ENTRIES))
		&& entry_valid_q[idx];
	assign beyond = offset_q > rdt_pkg::WORD_W'(rd_size);
	assign sum    = rd_base + offset_q[AB-1:0];
	assign rem    = rd_size - offset_q[AB-1:0];
	assign rsize  = ({1'b0, rd_size} + rdt_pkg::PAGE_M1_X) & rdt_pkg::ROUND_MASK;
	assign close_go = (cmd_q == rdt_pkg::CMD_CLOSE) && id_ok && (rsize != '0);

	// free-entry walk
	assign scan_free = !entry_valid_q[scan_q];
	assign scan_end  = (scan_q == rdt_pkg::ID_W'(rdt_pkg::ENTRIES - 1));

	// shared block-step unit for close
	rdt_blk u_blk (
		.addr(cl_addr_q),
		.size(cl_size_q),
		.step(step)
	);

	assign cl_last = (step.next_size == '0)
		|| (cl_cnt_q == rdt_pkg::RES_W'(rdt_pkg::MAX_RES - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rdt_pkg::ST_IDLE: begin
				if (accept) state_d = rdt_pkg::ST_DECODE;
			end
			rdt_pkg::ST_DECODE: begin
				state_d = (cmd_q == rdt_pkg::CMD_ALLOC) ? rdt_pkg::ST_SCAN
					: rdt_pkg::ST_EXEC;
			end
			rdt_pkg::ST_EXEC: begin
				state_d = close_go ? rdt_pkg::ST_CLOSE : rdt_pkg::ST_IDLE;
			end
			rdt_pkg::ST_SCAN: begin
				if (scan_free || scan_end) state_d = rdt_pkg::ST_IDLE;
			end
			rdt_pkg::ST_CLOSE: begin
				if (cl_last) state_d = rdt_pkg::ST_IDLE;
			end
			default: state_d = rdt_pkg::ST_IDLE;
		endcase
	end

	// result and table-update controls
	always_comb begin
		res_d     = '0;
		emit      = 1'b0;
		ram_we    = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		cl_load   = 1'b0;
		case (state_q)
			rdt_pkg::ST_EXEC: begin
				emit       = 1'b1;
				res_d.last = 1'b1;
				if (!id_ok || !(cmd_q inside {rdt_pkg::CMD_MAP, rdt_pkg::CMD_FAULT,
					rdt_pkg::CMD_CLOSE, rdt_pkg::CMD_PHYS})) begin
					res_d.status = rdt_pkg::STS_INVALID;
				end else begin
					case (cmd_q)
						rdt_pkg::CMD_MAP: begin
							if (write_q) begin
								res_d.status = rdt_pkg::STS_WDENIED;
							end else if (beyond) begin
								res_d.status = rdt_pkg::STS_BEYOND;
							end else if (length_q > rdt_pkg::WORD_W'(rdt_pkg::PAGE)
								&& !partial_q) begin
								res_d.status = rdt_pkg::STS_INVALID;
							end else begin
								res_d.status    = rdt_pkg::STS_OK;
								res_d.page_addr = rdt_pkg::WORD_W'(sum & rdt_pkg::PAGE_MASK);
								res_d.page_log2 = rdt_pkg::PLOG_W'(rdt_pkg::PAGE_LOG2);
								res_d.send_base = recv_q;
							end
						end
						rdt_pkg::CMD_FAULT: begin
							if (offset_q[1]) begin
								res_d.status = rdt_pkg::STS_INVALID;
							end else if (beyond) begin
								res_d.status = rdt_pkg::STS_BEYOND;
							end else begin
								res_d.status    = rdt_pkg::STS_OK;
								res_d.page_addr = rdt_pkg::WORD_W'(sum & rdt_pkg::PAGE_MASK);
								res_d.page_log2 = rdt_pkg::PLOG_W'(rdt_pkg::PAGE_LOG2);
							end
						end
						rdt_pkg::CMD_PHYS: begin
							if (beyond) begin
								res_d.status = rdt_pkg::STS_BEYOND;
							end else begin
								res_d.status    = rdt_pkg::STS_OK;
								res_d.page_addr = rdt_pkg::WORD_W'(sum);
								if (!whole_q && rdt_pkg::WORD_W'(rem) > length_q) begin
									res_d.avail_len = length_q;
								end else begin
									res_d.avail_len = rdt_pkg::WORD_W'(rem);
								end
							end
						end
						default: begin
							// close: free the entry; an empty region gives one ok result
							clr_valid    = 1'b1;
							res_d.status = rdt_pkg::STS_OK;
							if (close_go) begin
								emit    = 1'b0;
								cl_load = 1'b1;
							end
						end
					endcase
				end
			end
			rdt_pkg::ST_SCAN: begin
				if (scan_free) begin
					emit            = 1'b1;
					ram_we          = 1'b1;
					set_valid       = 1'b1;
					res_d.status    = rdt_pkg::STS_OK;
					res_d.ds_id_out = rdt_pkg::DSOUT_W'(scan_q);
					res_d.last      = 1'b1;
				end else if (scan_end) begin
					emit         = 1'b1;
					res_d.status = rdt_pkg::STS_NOFREE;
					res_d.last   = 1'b1;
				end
			end
			rdt_pkg::ST_CLOSE: begin
				emit              = 1'b1;
				res_d.status      = rdt_pkg::STS_OK;
				res_d.page_addr   = rdt_pkg::WORD_W'(cl_addr_q);
				res_d.page_log2   = rdt_pkg::PLOG_W'(step.fp);
				res_d.unmap_valid = 1'b1;
				res_d.unmap_task  = task_q;
				res_d.last        = cl_last;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= rdt_pkg::ST_IDLE;
			entry_valid_q <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= emit;
			if (set_valid) entry_valid_q[scan_q] <= 1'b1;
			if (clr_valid) entry_valid_q[idx] <= 1'b0;
		end
	end

	// command latch, walk counters and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			ds_id_q   <= ds_id;
			base_q    <= base_addr;
			length_q  <= length;
			offset_q  <= offset;
			write_q   <= write_flag;
			partial_q <= partial_flag;
			whole_q   <= whole_flag;
			recv_q    <= recv_offset;
			task_q    <= client_task;
			scan_q    <= '0;
		end else if (state_q == rdt_pkg::ST_SCAN) begin
			scan_q <= scan_q + 1'b1;
		end
		if (cl_load) begin
			cl_addr_q <= rd_base;
			cl_size_q <= rsize;
			cl_cnt_q  <= '0;
		end else if (state_q == rdt_pkg::ST_CLOSE) begin
			cl_addr_q <= step.next_addr;
			cl_size_q <= step.next_size;
			cl_cnt_q  <= cl_cnt_q + 1'b1;
		end
		if (emit) res_q <= res_d;
	end

	assign result_valid = res_valid_q;
	assign status       = res_q.status;
	assign ds_id_out    = res_q.ds_id_out;
	assign page_addr    = res_q.page_addr;
	assign page_log2    = res_q.page_log2;
	assign avail_len    = res_q.avail_len;
	assign send_base    = res_q.send_base;
	assign unmap_valid  = res_q.unmap_valid;
	assign unmap_task   = res_q.unmap_task;
	assign last         = res_q.last;

endmodule

`default_nettype wire

FILE: hdl/rdt_chk.sv
// Port-level checks for the region descriptor table, bound to the top level.
// Depends on rdt_pkg.
`default_nettype none

module rdt_chk (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire logic                       result_valid,
	input wire logic [2:0]                 status,
	input wire logic [rdt_pkg::PLOG_W-1:0] page_log2,
	input wire logic                       unmap_valid,
	input wire logic                       last
);

	// an accepted transaction holds the block busy and shows no result next
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !result_valid)
		else $error("accepted transaction did not raise busy or result appeared early");

	// only the final result may show while the block is free
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("non-final result while block idle");

	// an error ends the transaction
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != rdt_pkg::STS_OK |-> last && !unmap_valid)
		else $error("error result not final or carries a block");

	// unmap blocks are ok results within the address space
	a_blk_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && unmap_valid |->
			page_log2 <= rdt_pkg::PLOG_W'(rdt_pkg::ADDR_BITS))
		else $error("unmap block size out of range");

	// a final result is never followed at once by another
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result directly after final result");

endmodule

bind region_descriptor_table rdt_chk u_rdt_chk (.*);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Testbench for region_descriptor_table: directed and random command streams,
// each result checked against a behavioural model of the descriptor table.
// Depends on rdt_pkg and the RTL under hdl/.

module tb;
	import rdt_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 330;
	localparam int BLOCK_CAP    = MAX_RES;

	// Command codes with no operation behind them
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [DSIN_W-1:0]  ds_id;
		logic [WORD_W-1:0]  base_addr;
		logic [WORD_W-1:0]  length;
		logic [WORD_W-1:0]  offset;
		logic               write_flag;
		logic               partial_flag;
		logic               whole_flag;
		logic [WORD_W-1:0]  recv_offset;
		logic [TASK_W-1:0]  client_task;
	} region_req_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [DSOUT_W-1:0]  ds_id_out;
		logic [WORD_W-1:0]   page_addr;
		logic [PLOG_W-1:0]   page_log2;
		logic [WORD_W-1:0]   avail_len;
		logic [WORD_W-1:0]   send_base;
		logic                unmap_valid;
		logic [TASK_W-1:0]   unmap_task;
		logic                last;
	} region_res_t;

	// DUT inputs, known from time zero
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic [CMD_W-1:0]    cmd          = '0;
	logic [DSIN_W-1:0]   ds_id        = '0;
	logic [WORD_W-1:0]   base_addr    = '0;
	logic [WORD_W-1:0]   length       = '0;
	logic [WORD_W-1:0]   offset       = '0;
	logic                write_flag   = 1'b0;
	logic                partial_flag = 1'b0;
	logic                whole_flag   = 1'b0;
	logic [WORD_W-1:0]   recv_offset  = '0;
	logic [TASK_W-1:0]   client_task  = '0;

	// DUT outputs
	logic                busy;
	logic                result_valid;
	logic [2:0]          status;
	logic [DSOUT_W-1:0]  ds_id_out;
	logic [WORD_W-1:0]   page_addr;
	logic [PLOG_W-1:0]   page_log2;
	logic [WORD_W-1:0]   avail_len;
	logic [WORD_W-1:0]   send_base;
	logic                unmap_valid;
	logic [TASK_W-1:0]   unmap_task;
	logic                last;

	// Model copy of the descriptor table
	bit                  table_valid [ENTRIES];
	bit                  table_touched [ENTRIES];
	logic [WORD_W-1:0]   table_base [ENTRIES];
	logic [WORD_W-1:0]   table_size [ENTRIES];

	region_res_t         expected_results [$];
	int                  mismatch_count = 0;
	bit                  no_idle = 1'b0;

	region_descriptor_table i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.ds_id        (ds_id),
		.base_addr    (base_addr),
		.length       (length),
		.offset       (offset),
		.write_flag   (write_flag),
		.partial_flag (partial_flag),
		.whole_flag   (whole_flag),
		.recv_offset  (recv_offset),
		.client_task  (client_task),
		.result_valid (result_valid),
		.status       (status),
		.ds_id_out    (ds_id_out),
		.page_addr    (page_addr),
		.page_log2    (page_log2),
		.avail_len    (avail_len),
		.send_base    (send_base),
		.unmap_valid  (unmap_valid),
		.unmap_task   (unmap_task),
		.last         (last)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Work out the results of one accepted command and update the table copy
	task automatic predict_region_op(input region_req_t rq);
		region_res_t          r;
		int                   idx;
		bit                   id_ok;
		logic [ADDR_BITS-1:0] blk_addr;
		logic [ADDR_BITS:0]   blk_left;
		logic [ADDR_BITS:0]   blk_size;
		logic [WORD_W-1:0]    rem;
		int                   align;
		int                   msb;
		int                   fp;
		int                   k;
		r = '0;
		r.last = 1'b1;
		idx = int'(rq.ds_id) % ENTRIES;
		id_ok = (rq.ds_id < ENTRIES) && table_valid[idx];

		if (rq.cmd == CMD_ALLOC) begin
			r.status = STS_NOFREE;
			for (int i = 0; i < ENTRIES; i++) begin
				if (!table_valid[i] && r.status == STS_NOFREE) begin
					table_valid[i] = 1'b1;
					table_touched[i] = 1'b1;
					table_base[i] = rq.base_addr;
					table_size[i] = rq.length;
					r.status = STS_OK;
					r.ds_id_out = DSOUT_W'(i);
				end
			end
		end else if (rq.cmd > CMD_PHYS || !id_ok) begin
			r.status = STS_INVALID;
		end else if (rq.cmd == CMD_MAP || rq.cmd == CMD_FAULT) begin
			if (rq.cmd == CMD_MAP && rq.write_flag)
				r.status = STS_WDENIED;
			else if (rq.cmd == CMD_FAULT && rq.offset[1])
				r.status = STS_INVALID;
			else if (rq.offset > table_size[idx])
				r.status = STS_BEYOND;
			else if (rq.cmd == CMD_MAP && rq.length > PAGE && !rq.partial_flag)
				r.status = STS_INVALID;
			else begin
				r.status = STS_OK;
				r.page_addr = (table_base[idx] + rq.offset) & PAGE_MASK;
				r.page_log2 = PLOG_W'(PAGE_LOG2);
				r.send_base = (rq.cmd == CMD_MAP) ? rq.recv_offset : '0;
			end
		end else if (rq.cmd == CMD_PHYS) begin
			if (rq.offset > table_size[idx])
				r.status = STS_BEYOND;
			else begin
				rem = table_size[idx] - rq.offset;
				if (!rq.whole_flag && rem > rq.length)
					rem = rq.length;
				r.status = STS_OK;
				r.page_addr = table_base[idx] + rq.offset;
				r.avail_len = rem;
			end
		end else begin
			// close: free the entry, then walk aligned blocks over the page-rounded size
			table_valid[idx] = 1'b0;
			blk_addr = table_base[idx];
			blk_left = ({1'b0, table_size[idx]} + PAGE_M1_X) & ROUND_MASK;
			r.status = STS_OK;
			if (blk_left != '0) begin
				k = 0;
				while (blk_left != '0 && k < BLOCK_CAP) begin
					align = ADDR_BITS;
					for (int b = ADDR_BITS - 1; b >= 0; b--)
						if (blk_addr[b])
							align = b;
					msb = 0;
					for (int b = 0; b <= ADDR_BITS; b++)
						if (blk_left[b])
							msb = b;
					fp = (align < msb) ? align : msb;
					blk_size = (ADDR_BITS + 1)'(1) << fp;
					blk_left = blk_left - blk_size;
					r.page_addr = blk_addr;
					r.page_log2 = PLOG_W'(fp);
					r.unmap_valid = 1'b1;
					r.unmap_task = rq.client_task;
					r.last = (blk_left == '0) || (k == BLOCK_CAP - 1);
					expected_results.push_back(r);
					blk_addr = blk_addr + blk_size[ADDR_BITS-1:0];
					k++;
				end
				return;
			end
		end
		expected_results.push_back(r);
	endtask

	// Idle gap before a command: mostly short, a few long
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (no_idle || sel < 45)
			return 0;
		else if (sel < 85)
			return $urandom_range(1, 3);
		else if (sel < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Drive one command and hold it until the block takes it
	task automatic issue_request(input region_req_t rq, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		cmd          <= rq.cmd;
		ds_id        <= rq.ds_id;
		base_addr    <= rq.base_addr;
		length       <= rq.length;
		offset       <= rq.offset;
		write_flag   <= rq.write_flag;
		partial_flag <= rq.partial_flag;
		whole_flag   <= rq.whole_flag;
		recv_offset  <= rq.recv_offset;
		client_task  <= rq.client_task;
		do
			@(posedge clk);
		while (busy);
		predict_region_op(rq);
	endtask

	function automatic region_req_t random_req();
		region_req_t rq;
		rq.cmd          = CMD_W'($urandom_range(0, CMD_SPARE_HI));
		rq.ds_id        = DSIN_W'($urandom);
		rq.base_addr    = $urandom;
		rq.length       = $urandom;
		rq.offset       = $urandom;
		rq.write_flag   = 1'($urandom);
		rq.partial_flag = 1'($urandom);
		rq.whole_flag   = 1'($urandom);
		rq.recv_offset  = $urandom;
		rq.client_task  = TASK_W'($urandom);
		return rq;
	endfunction

	function automatic region_req_t make_req(input logic [CMD_W-1:0] op,
			input logic [DSIN_W-1:0] id, input logic [WORD_W-1:0] base,
			input logic [WORD_W-1:0] len, input logic [WORD_W-1:0] off);
		region_req_t rq;
		rq = random_req();
		rq.cmd          = op;
		rq.ds_id        = id;
		rq.base_addr    = base;
		rq.length       = len;
		rq.offset       = off;
		rq.write_flag   = 1'b0;
		rq.partial_flag = 1'b0;
		rq.whole_flag   = 1'b0;
		return rq;
	endfunction

	function automatic int lowest_free();
		for (int i = 0; i < ENTRIES; i++)
			if (!table_valid[i])
				return i;
		return -1;
	endfunction

	// Only entries that have been written are ever addressed, in range or aliased above it
	function automatic logic [DSIN_W-1:0] pick_id();
		int                cand [$];
		logic [DSIN_W-1:0] id;
		for (int i = 0; i < ENTRIES; i++)
			if (table_touched[i])
				cand.push_back(i);
		id = DSIN_W'(cand[$urandom_range(0, cand.size() - 1)]);
		if ($urandom_range(0, 3) == 0)
			id[DSIN_W-1:ID_W] = 2'($urandom_range(1, 3));
		return id;
	endfunction

	function automatic logic [WORD_W-1:0] pick_base();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return $urandom & PAGE_MASK;
			2:       return 32'hFFFF_F000 | WORD_W'($urandom_range(0, PAGE - 1));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return $urandom;
			2:       return 32'hFFFF_F000 | WORD_W'($urandom_range(0, PAGE - 1));
			3:       return $urandom_range(1, PAGE);
			default: return $urandom_range(0, 32'h0002_0000);
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_offset(input logic [WORD_W-1:0] size);
		case ($urandom_range(0, 7))
			0:       return size;
			1:       return size + 1'b1;
			2:       return $urandom;
			3:       return '0;
			default: return $urandom_range(size, 0);
		endcase
	endfunction

	// A map, fault or phys query on a live entry, mostly well formed
	function automatic region_req_t access_req(input int ix);
		region_req_t rq;
		rq = random_req();
		rq.ds_id = DSIN_W'(ix);
		rq.offset = pick_offset(table_size[ix]);
		case ($urandom_range(0, 2))
			0: begin
				rq.cmd = CMD_MAP;
				rq.write_flag = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 1))
					rq.length = $urandom_range(0, PAGE);
			end
			1: begin
				rq.cmd = CMD_FAULT;
				if ($urandom_range(0, 3) != 0)
					rq.offset[1] = 1'b0;
			end
			default: begin
				rq.cmd = CMD_PHYS;
				if ($urandom_range(0, 1))
					rq.length = $urandom_range(0, 32'h0001_0000);
			end
		endcase
		return rq;
	endfunction

	// Allocations at the extremes of base and size
	task automatic test_alloc_edges();
		issue_request(make_req(CMD_ALLOC, '0, 32'h0000_1000, 32'h0000_3000, '0), pick_gap());
		issue_request(make_req(CMD_ALLOC, '1, 32'hFFFF_F123, 32'hFFFF_FFFF, '1), pick_gap());
		issue_request(make_req(CMD_ALLOC, '0, '0, '0, '0), pick_gap());
		issue_request(make_req(CMD_ALLOC, '0, 32'h0000_0001, 32'hFFFF_F000, '0), pick_gap());
		issue_request(make_req(CMD_ALLOC, '0, '0, 32'hFFFF_FFFF, '0), pick_gap());
	endtask

	// Map and fault: each refusal in check order, then id errors
	task automatic test_map_fault_checks();
		region_req_t rq;
		issue_request(make_req(CMD_MAP, 8'd0, '0, PAGE, 32'h0000_3000), pick_gap());
		rq = make_req(CMD_MAP, 8'd0, '0, PAGE, 32'h0000_0010);
		rq.write_flag = 1'b1;
		issue_request(rq, pick_gap());
		issue_request(make_req(CMD_MAP, 8'd0, '0, PAGE, 32'h0000_3001), pick_gap());
		issue_request(make_req(CMD_MAP, 8'd0, '0, PAGE + 1, 32'h0000_1000), pick_gap());
		rq = make_req(CMD_MAP, 8'd0, '0, 32'hFFFF_FFFF, 32'h0000_2FFF);
		rq.partial_flag = 1'b1;
		issue_request(rq, pick_gap());
		issue_request(make_req(CMD_FAULT, 8'd1, '0, '0, 32'hFFFF_FFFD), pick_gap());
		issue_request(make_req(CMD_FAULT, 8'd0, '0, '0, 32'h0000_0002), pick_gap());
		issue_request(make_req(CMD_FAULT, 8'd0, '0, '0, 32'h0000_3004), pick_gap());
		issue_request(make_req(CMD_MAP, 8'hC1, '0, PAGE, '0), pick_gap());
		issue_request(make_req(CMD_FAULT, 8'h40, '0, '0, '0), pick_gap());
	endtask

	// Phys query: clamp, whole remainder, wrap, beyond end, spare codes
	task automatic test_phys_query();
		region_req_t rq;
		issue_request(make_req(CMD_PHYS, 8'd0, '0, 32'h0000_0100, 32'h0000_1000), pick_gap());
		rq = make_req(CMD_PHYS, 8'd0, '0, 32'h0000_0100, 32'h0000_1000);
		rq.whole_flag = 1'b1;
		issue_request(rq, pick_gap());
		issue_request(make_req(CMD_PHYS, 8'd1, '0, '0, 32'hFFFF_FFFF), pick_gap());
		issue_request(make_req(CMD_PHYS, 8'd0, '0, '1, 32'h0000_3001), pick_gap());
		issue_request(make_req(CMD_SPARE_LO, 8'd0, '0, '0, '0), pick_gap());
		issue_request(make_req(CMD_SPARE_HI, 8'd1, '0, '0, '0), pick_gap());
	endtask

	// Close: carry out of the rounding, empty region, long walk, zero base, reuse
	task automatic test_close_blocks();
		region_req_t rq;
		rq = make_req(CMD_CLOSE, 8'd1, '0, '0, '0);
		rq.client_task = '1;
		issue_request(rq, pick_gap());
		issue_request(make_req(CMD_CLOSE, 8'd2, '0, '0, '0), pick_gap());
		issue_request(make_req(CMD_CLOSE, 8'd3, '0, '0, '0), pick_gap());
		rq = make_req(CMD_CLOSE, 8'd4, '0, '0, '0);
		rq.client_task = '0;
		issue_request(rq, pick_gap());
		issue_request(make_req(CMD_CLOSE, 8'd0, '0, '0, '0), pick_gap());
		issue_request(make_req(CMD_CLOSE, 8'd1, '0, '0, '0), pick_gap());
	endtask

	// Fill every entry, ask once more, then release in a scattered order
	task automatic test_table_full();
		region_req_t rq;
		int          ix;
		while (lowest_free() >= 0) begin
			rq = random_req();
			rq.cmd = CMD_ALLOC;
			rq.length = $urandom_range(0, 4 * PAGE);
			issue_request(rq, pick_gap());
		end
		rq = random_req();
		rq.cmd = CMD_ALLOC;
		issue_request(rq, pick_gap());
		for (int n = 0; n < ENTRIES; n++) begin
			ix = (n * 37) % ENTRIES;
			rq = random_req();
			rq.cmd = CMD_CLOSE;
			rq.ds_id = DSIN_W'(ix);
			issue_request(rq, pick_gap());
		end
	endtask

	// Mostly alloc / access / close sessions, with some noise commands mixed in
	task automatic test_random_traffic();
		region_req_t rq;
		int          sent;
		int          free_ix;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) < 7) begin
				free_ix = lowest_free();
				rq = random_req();
				rq.cmd = CMD_ALLOC;
				rq.base_addr = pick_base();
				rq.length = pick_size();
				issue_request(rq, pick_gap());
				sent++;
				if (free_ix >= 0) begin
					repeat ($urandom_range(1, 5)) begin
						issue_request(access_req(free_ix), pick_gap());
						sent++;
					end
					if ($urandom_range(0, 9) < 6) begin
						rq = random_req();
						rq.cmd = CMD_CLOSE;
						rq.ds_id = DSIN_W'(free_ix);
						issue_request(rq, pick_gap());
						sent++;
					end
				end
			end else begin
				rq = random_req();
				rq.ds_id = pick_id();
				issue_request(rq, pick_gap());
				sent++;
			end
		end
		no_idle = 1'b0;
	endtask

	function automatic void check_field(input string name, input logic [WORD_W-1:0] want_v,
			input logic [WORD_W-1:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
			mismatch_count++;
		end
	endfunction

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		region_res_t want;
		if (result_valid) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d page %h",
					$time, status, page_addr);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", WORD_W'(want.status), WORD_W'(status));
				check_field("ds_id_out", WORD_W'(want.ds_id_out), WORD_W'(ds_id_out));
				check_field("page_addr", want.page_addr, page_addr);
				check_field("page_log2", WORD_W'(want.page_log2), WORD_W'(page_log2));
				check_field("avail_len", want.avail_len, avail_len);
				check_field("send_base", want.send_base, send_base);
				check_field("unmap_valid", WORD_W'(want.unmap_valid), WORD_W'(unmap_valid));
				check_field("unmap_task", WORD_W'(want.unmap_task), WORD_W'(unmap_task));
				check_field("last", WORD_W'(want.last), WORD_W'(last));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || result_valid)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_alloc_edges();
		test_map_fault_checks();
		test_phys_query();
		test_close_blocks();
		test_table_full();
		test_random_traffic();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
hdl/rdt_pkg.sv
hdl/rdt_ram.sv
hdl/rdt_blk.sv
hdl/region_descriptor_table.sv
hdl/rdt_chk.sv
tb/tb.sv
